[rtl/core/slab_pkg.sv]
// package: constants, per-class tables and shared types for the slab allocator
`default_nettype none
package slab_pkg;
    localparam int NumPages     = 64;
    localparam int PageBytes    = 4096;
    localparam int HeaderBytes  = 20;
    localparam int PointerBytes = 4;
    localparam int NumClasses   = 9;
    localparam int NumLists     = NumClasses * 3;
    localparam int StackDepth   = (PageBytes - HeaderBytes) / (4 + PointerBytes);
    localparam int PageW        = $clog2(NumPages);
    localparam int PtrW         = PageW + 1;
    localparam int CountW       = $clog2(StackDepth + 1);
    localparam int SlotW        = $clog2(StackDepth);
    localparam int StackAddrW   = $clog2(NumPages * StackDepth);
    localparam int OffW         = $clog2(PageBytes);
    localparam int ListW        = $clog2(NumLists);
    localparam int ClassW       = 4;
    localparam int AddrW        = 18;
    localparam int LimitW       = 7;
    localparam int QDepth       = 2;

    // objects per page of each class
    localparam int PerSlab0 = (PageBytes - HeaderBytes) / ((4 << 0) + PointerBytes);
    localparam int PerSlab1 = (PageBytes - HeaderBytes) / ((4 << 1) + PointerBytes);
    localparam int PerSlab2 = (PageBytes - HeaderBytes) / ((4 << 2) + PointerBytes);
    localparam int PerSlab3 = (PageBytes - HeaderBytes) / ((4 << 3) + PointerBytes);
    localparam int PerSlab4 = (PageBytes - HeaderBytes) / ((4 << 4) + PointerBytes);
    localparam int PerSlab5 = (PageBytes - HeaderBytes) / ((4 << 5) + PointerBytes);
    localparam int PerSlab6 = (PageBytes - HeaderBytes) / ((4 << 6) + PointerBytes);
    localparam int PerSlab7 = (PageBytes - HeaderBytes) / ((4 << 7) + PointerBytes);
    localparam int PerSlab8 = (PageBytes - HeaderBytes) / ((4 << 8) + PointerBytes);

    // byte offset of slot 0 in a page of each class
    localparam int ObjBase0 = PageBytes - PerSlab0 * (4 << 0);
    localparam int ObjBase1 = PageBytes - PerSlab1 * (4 << 1);
    localparam int ObjBase2 = PageBytes - PerSlab2 * (4 << 2);
    localparam int ObjBase3 = PageBytes - PerSlab3 * (4 << 3);
    localparam int ObjBase4 = PageBytes - PerSlab4 * (4 << 4);
    localparam int ObjBase5 = PageBytes - PerSlab5 * (4 << 5);
    localparam int ObjBase6 = PageBytes - PerSlab6 * (4 << 6);
    localparam int ObjBase7 = PageBytes - PerSlab7 * (4 << 7);
    localparam int ObjBase8 = PageBytes - PerSlab8 * (4 << 8);

    localparam logic [PtrW-1:0] NoPage = PtrW'(NumPages);

    localparam logic [1:0] KindEmpty   = 2'd0;
    localparam logic [1:0] KindPartial = 2'd1;
    localparam logic [1:0] KindFull    = 2'd2;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StTooLarge = 3'd1;
    localparam logic [2:0] StNoPool   = 3'd2;
    localparam logic [2:0] StBadFree  = 3'd3;
    localparam logic [2:0] StAllFree  = 3'd4;

    // objects per page of a class
    function automatic logic [CountW-1:0] per_slab(input logic [ClassW-1:0] c);
        logic [CountW-1:0] r;
        case (c)
            4'd0: r = CountW'(PerSlab0);
            4'd1: r = CountW'(PerSlab1);
            4'd2: r = CountW'(PerSlab2);
            4'd3: r = CountW'(PerSlab3);
            4'd4: r = CountW'(PerSlab4);
            4'd5: r = CountW'(PerSlab5);
            4'd6: r = CountW'(PerSlab6);
            4'd7: r = CountW'(PerSlab7);
            4'd8: r = CountW'(PerSlab8);
            default: r = '0;
        endcase
        return r;
    endfunction

    // byte offset of slot 0 in the page
    function automatic logic [OffW:0] obj_base(input logic [ClassW-1:0] c);
        logic [OffW:0] r;
        case (c)
            4'd0: r = (OffW+1)'(ObjBase0);
            4'd1: r = (OffW+1)'(ObjBase1);
            4'd2: r = (OffW+1)'(ObjBase2);
            4'd3: r = (OffW+1)'(ObjBase3);
            4'd4: r = (OffW+1)'(ObjBase4);
            4'd5: r = (OffW+1)'(ObjBase5);
            4'd6: r = (OffW+1)'(ObjBase6);
            4'd7: r = (OffW+1)'(ObjBase7);
            4'd8: r = (OffW+1)'(ObjBase8);
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic                  is_free;
        logic                  too_large;
        logic [ClassW-1:0]     cls;
        logic [AddrW-1:0]      addr;
    } t_cmd;
endpackage
`default_nettype wire

[rtl/core/slab_size_class_allocator.sv]
// top level of the slab allocator
// Requests enter a two-entry queue and are served one at a time by the engine, which
// steps through fetch, list lookup, metadata read, stack read, metadata update and
// result hand-over; when the page moves to another list, link and tail steps after
// the update append it to the new tail, and a request rejected at lookup (size too
// large, pool exhausted, unowned page) goes straight to hand-over. The
// rate is set by the engine's read-modify-write sequence on the metadata, link and
// free-stack memories; a result not yet popped holds the engine in hand-over, after
// which the queue fills and full rises. No clearing pass is needed after reset.
`default_nettype none
module slab_size_class_allocator import slab_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              i_mode,
    input  wire logic [15:0]       i_request_size,
    input  wire logic [AddrW-1:0]  i_object_address,
    output logic                   empty,
    input  wire logic              pop,
    output logic [2:0]             o_status,
    output logic [AddrW-1:0]       o_granted_address,
    output logic [ClassW-1:0]      o_size_class,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [LimitW-1:0] i_cfg_page_limit
);
    logic [LimitW-1:0] r_limit;
    logic w_cv, w_take;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= LimitW'(64);
        else if (i_cfg_valid) r_limit <= i_cfg_page_limit;
    end

    slab_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_mode, .i_request_size, .i_object_address,
        .o_cmd_valid(w_cv), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );
    slab_engine u_engine (
        .i_clk, .i_rst_n, .i_limit(r_limit), .i_cmd_valid(w_cv), .i_cmd(w_cmd),
        .o_cmd_take(w_take), .empty, .pop, .o_status, .o_granted_address, .o_size_class
    );
endmodule
`default_nettype wire

[rtl/core/slab_front.sv]
// front end: classifies requests and queues them for the engine
`default_nettype none
module slab_front import slab_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              i_mode,
    input  wire logic [15:0]       i_request_size,
    input  wire logic [AddrW-1:0]  i_object_address,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  wire logic              i_cmd_take
);
    t_cmd r_q [QDepth];
    logic [$clog2(QDepth)-1:0] r_wp, r_rp;
    logic [$clog2(QDepth):0]   r_cnt;
    t_cmd w_c;
    logic w_push, w_pop;

    always_comb begin
        w_c = '0;
        w_c.is_free = i_mode;
        w_c.addr = i_object_address;
        w_c.cls = ClassW'(NumClasses);
        for (int k = NumClasses - 1; k >= 0; k--)
            if ({16'd0, i_request_size} <= 32'(4 << k)) w_c.cls = ClassW'(k);
        w_c.too_large = !i_mode && (w_c.cls == ClassW'(NumClasses));
        if (w_c.too_large) w_c.cls = '0;
    end

    assign full = (r_cnt == ($clog2(QDepth)+1)'(QDepth));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rp];
    assign w_push = push && !full;
    assign w_pop = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + ($clog2(QDepth)+1)'(w_push) - ($clog2(QDepth)+1)'(w_pop);
        end
        if (w_push) r_q[r_wp] <= w_c;
    end
endmodule
`default_nettype wire

[rtl/core/slab_engine.sv]
// back end: page metadata, free stacks and class lists
`default_nettype none
module slab_engine import slab_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [LimitW-1:0] i_limit,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_cmd_take,
    output logic                   empty,
    input  wire logic              pop,
    output logic [2:0]             o_status,
    output logic [AddrW-1:0]       o_granted_address,
    output logic [ClassW-1:0]      o_size_class
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_LOOK = 8'b00000010, S_META = 8'b00000100,
        S_READ = 8'b00001000, S_UPD = 8'b00010000, S_LINK = 8'b00100000,
        S_TAIL = 8'b01000000, S_DONE = 8'b10000000
    } t_state;

    typedef struct packed {
        logic [ClassW-1:0] cls;
        logic [CountW-1:0] fcnt;
        logic [CountW-1:0] ucnt;
    } t_meta;

    t_state r_state;
    logic [NumPages-1:0]  r_owned;
    t_meta                r_mmem  [NumPages];
    logic [PtrW-1:0]      r_next  [NumPages];
    logic [PtrW-1:0]      r_prev  [NumPages];
    logic [PtrW-1:0]      r_head  [NumLists];
    logic [PtrW-1:0]      r_tail  [NumLists];
    logic [SlotW-1:0]     r_stack [NumPages * StackDepth];
    logic [PtrW-1:0]      r_used;
    t_cmd                 r_cmd;
    logic [PageW-1:0]     r_page;
    t_meta                r_meta;
    logic [PtrW-1:0]      r_pv, r_nx, r_t;
    logic [ListW-1:0]     r_ln;
    logic [SlotW-1:0]     r_sdata;
    logic [2:0]           r_st;
    logic [AddrW-1:0]     r_ga;
    logic [ClassW-1:0]    r_cl;
    logic                 r_full;
    logic                 n_full;
    logic [2:0]           r_ost;
    logic [AddrW-1:0]     r_oga;
    logic [ClassW-1:0]    r_ocl;

    logic [OffW:0]        w_base;
    logic [OffW-1:0]      w_off;
    logic [PageW-1:0]     w_fpage;
    logic [OffW:0]        w_rel;
    logic [OffW:0]        w_mask;
    logic [PtrW-1:0]      w_cap;
    logic [CountW-1:0]    w_fc, w_ps, w_pos, w_nfc, w_wpos, w_nucnt;
    logic [1:0]           w_ok, w_nk;
    logic [ListW-1:0]     w_lo, w_ln, w_lp, w_le;
    logic [SlotW-1:0]     w_slot, w_fslot;
    logic [PtrW-1:0]      w_t;
    logic [StackAddrW-1:0] w_sa;

    assign empty = !r_full;
    assign o_status = r_ost;
    assign o_granted_address = r_oga;
    assign o_size_class = r_ocl;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    assign w_off = r_cmd.addr[OffW-1:0];
    assign w_fpage = PageW'(r_cmd.addr >> OffW);
    assign w_cap = (i_limit < LimitW'(NumPages)) ? PtrW'(i_limit) : PtrW'(NumPages);
    assign w_lp = ListW'(r_cmd.cls * 3 + KindPartial);
    assign w_le = ListW'(r_cmd.cls * 3 + KindEmpty);

    // everything below works on the registered metadata of r_page
    assign w_base = obj_base(r_meta.cls);
    assign w_rel = {1'b0, w_off} - w_base;
    assign w_mask = (OffW+1)'((4 << r_meta.cls) - 1);
    assign w_fc = r_meta.fcnt;
    assign w_ps = per_slab(r_meta.cls);
    assign w_pos = r_cmd.is_free ? w_fc : w_fc - 1'b1;
    assign w_nfc = r_cmd.is_free ? w_fc + 1'b1 : w_fc - 1'b1;
    assign w_nucnt = (r_cmd.is_free && w_pos < r_meta.ucnt) ? w_pos : r_meta.ucnt;
    assign w_ok = (w_fc == '0) ? KindFull : (w_fc == w_ps) ? KindEmpty : KindPartial;
    assign w_nk = (w_nfc == '0) ? KindFull : (w_nfc == w_ps) ? KindEmpty : KindPartial;
    assign w_lo = ListW'(r_meta.cls * 3 + w_ok);
    assign w_ln = ListW'(r_meta.cls * 3 + w_nk);
    assign w_fslot = SlotW'(w_rel >> r_meta.cls >> 2);
    // stack position wraps at the stack depth
    assign w_wpos = (w_pos == CountW'(StackDepth)) ? '0 : w_pos;
    assign w_sa = StackAddrW'(r_page * StackDepth) + StackAddrW'(w_wpos);
    assign w_slot = (w_pos < r_meta.ucnt) ? SlotW'(w_pos) : r_sdata;
    assign w_t = r_tail[w_ln];

    always_comb begin
        n_full = r_full;
        if (r_full && pop) n_full = 1'b0;
        if (r_state == S_DONE && (!r_full || pop)) n_full = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_owned <= '0;
            r_used <= '0;
            r_full <= 1'b0;
            for (int i = 0; i < NumLists; i++) begin
                r_head[i] <= NoPage; r_tail[i] <= NoPage;
            end
        end else begin
            r_full <= n_full;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_st <= StOk; r_ga <= '0; r_cl <= '0;
                    r_state <= S_DONE;
                    if (r_cmd.too_large) begin
                        r_st <= StTooLarge;
                    end else if (r_cmd.is_free) begin
                        r_page <= w_fpage;
                        if ({1'b0, r_cmd.addr} >= (AddrW+1)'(NumPages * PageBytes)
                            || !r_owned[w_fpage])
                            r_st <= StBadFree;
                        else r_state <= S_META;
                    end else begin
                        r_cl <= r_cmd.cls;
                        if (r_head[w_lp] != NoPage) begin
                            r_page <= PageW'(r_head[w_lp]);
                            r_state <= S_META;
                        end else if (r_head[w_le] != NoPage) begin
                            r_page <= PageW'(r_head[w_le]);
                            r_state <= S_META;
                        end else if (r_used < w_cap) begin
                            r_page <= PageW'(r_used);
                            r_used <= r_used + 1'b1;
                            r_owned[PageW'(r_used)] <= 1'b1;
                            r_mmem[PageW'(r_used)] <= '{cls: r_cmd.cls,
                                fcnt: per_slab(r_cmd.cls), ucnt: per_slab(r_cmd.cls)};
                            // a fresh page is the only one of its empty list
                            r_prev[PageW'(r_used)] <= NoPage;
                            r_next[PageW'(r_used)] <= NoPage;
                            r_head[w_le] <= r_used;
                            r_tail[w_le] <= r_used;
                            r_state <= S_META;
                        end else r_st <= StNoPool;
                    end
                end
                S_META: begin
                    r_meta <= r_mmem[r_page];
                    r_pv <= r_prev[r_page];
                    r_nx <= r_next[r_page];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_sdata <= r_stack[w_sa];
                    r_state <= S_UPD;
                    if (r_cmd.is_free) begin
                        if (w_off < w_base[OffW-1:0] || w_base[OffW]
                            || (w_rel & w_mask) != '0) begin
                            r_st <= StBadFree;
                            r_state <= S_DONE;
                        end else begin
                            r_cl <= r_meta.cls;
                            if (w_fc >= w_ps) begin
                                r_st <= StAllFree;
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_UPD: begin
                    r_mmem[r_page] <= '{cls: r_meta.cls, fcnt: w_nfc, ucnt: w_nucnt};
                    if (r_cmd.is_free) begin
                        r_stack[w_sa] <= w_fslot;
                    end else begin
                        r_ga <= AddrW'({r_page, {OffW{1'b0}}}) + AddrW'(w_base)
                              + ((AddrW'(w_slot) << r_meta.cls) << 2);
                    end
                    r_state <= S_DONE;
                    if (w_nk != w_ok) begin
                        // unlink from old list here, append to new tail after
                        if (r_pv == NoPage) r_head[w_lo] <= r_nx;
                        else r_next[PageW'(r_pv)] <= r_nx;
                        if (r_nx == NoPage) r_tail[w_lo] <= r_pv;
                        else r_prev[PageW'(r_nx)] <= r_pv;
                        r_t <= w_t;
                        r_ln <= w_ln;
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_prev[r_page] <= r_t;
                    if (r_t == NoPage) r_head[r_ln] <= PtrW'(r_page);
                    else r_next[PageW'(r_t)] <= PtrW'(r_page);
                    r_tail[r_ln] <= PtrW'(r_page);
                    r_state <= S_TAIL;
                end
                S_TAIL: begin
                    r_next[r_page] <= NoPage;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_full || pop) begin
                        r_ost <= r_st; r_oga <= r_ga; r_ocl <= r_cl;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/slab_checker.sv]
// port-level checker for the slab allocator
`default_nettype none
module slab_checker import slab_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [2:0]       o_status,
    input wire logic [AddrW-1:0] o_granted_address,
    input wire logic [ClassW-1:0] o_size_class
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= StAllFree)) else $error("bad status");
    a_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_size_class < ClassW'(NumClasses))) else $error("bad class");
    a_err_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != StOk) |-> (o_granted_address == '0)) else $error("addr");
    a_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == StTooLarge) |-> (o_size_class == '0)) else $error("cls");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_granted_address))) else $error("hold");
endmodule

bind slab_size_class_allocator slab_checker u_chk (.*);
`default_nettype wire

[sim/slab_size_class_allocator_tb.sv]
// testbench for the slab size-class allocator: directed and random alloc/free traffic checked by a scoreboard
`timescale 1ns / 100ps
module slab_size_class_allocator_tb;
    import slab_pkg::*;

    class slab_scoreboard;
        int unsigned  limit;
        bit           owned [NumPages];
        int unsigned  cls_of [NumPages];
        int unsigned  free_cnt [NumPages];
        int unsigned  untouched [NumPages];
        int unsigned  stk [NumPages][StackDepth];
        int unsigned  nxt [NumPages];
        int unsigned  prv [NumPages];
        int unsigned  head [NumLists];
        int unsigned  tail [NumLists];
        int unsigned  used;
        logic [2:0]        q_status [$];
        logic [AddrW-1:0]  q_addr [$];
        logic [ClassW-1:0] q_cls [$];
        int           errors;

        function new();
            limit = 64;
            used = 0;
            errors = 0;
            foreach (owned[i]) owned[i] = 0;
            foreach (head[i]) begin
                head[i] = NumPages;
                tail[i] = NumPages;
            end
        endfunction

        function int unsigned objsz(int unsigned c);
            return 4 << c;
        endfunction

        function int unsigned slab_count(int unsigned c);
            return (PageBytes - HeaderBytes) / (objsz(c) + PointerBytes);
        endfunction

        function int unsigned base_of(int unsigned c);
            return PageBytes - slab_count(c) * objsz(c);
        endfunction

        function int unsigned kind(int unsigned p);
            if (free_cnt[p] == 0) return KindFull;
            if (free_cnt[p] == slab_count(cls_of[p])) return KindEmpty;
            return KindPartial;
        endfunction

        function void unlink(int unsigned l, int unsigned p);
            if (prv[p] >= NumPages) head[l] = nxt[p]; else nxt[prv[p]] = nxt[p];
            if (nxt[p] >= NumPages) tail[l] = prv[p]; else prv[nxt[p]] = prv[p];
        endfunction

        function void append(int unsigned l, int unsigned p);
            prv[p] = tail[l];
            nxt[p] = NumPages;
            if (tail[l] >= NumPages) head[l] = p; else nxt[tail[l]] = p;
            tail[l] = p;
        endfunction

        function void move_list(int unsigned p, int unsigned old_k);
            int unsigned nk;
            nk = kind(p);
            if (nk != old_k) begin
                unlink(cls_of[p] * 3 + old_k, p);
                append(cls_of[p] * 3 + nk, p);
            end
        endfunction

        // predict the outcome of one accepted request
        function void note_request(bit is_free, int unsigned size, int unsigned addr);
            int unsigned st, ga, c, p, cap, k, pos, slot, off;
            st = StOk; ga = 0; c = 0;
            if (!is_free) begin
                while (c < NumClasses && size > objsz(c)) c++;
                if (c >= NumClasses) begin
                    st = StTooLarge;
                    c = 0;
                end else begin
                    cap = limit < NumPages ? limit : NumPages;
                    p = head[c * 3 + KindPartial];
                    if (p >= NumPages) p = head[c * 3 + KindEmpty];
                    if (p >= NumPages && used < cap) begin
                        p = used++;
                        owned[p] = 1;
                        cls_of[p] = c;
                        free_cnt[p] = slab_count(c);
                        untouched[p] = slab_count(c);
                        append(c * 3 + KindEmpty, p);
                    end
                    if (p >= NumPages) st = StNoPool;
                    else begin
                        k = kind(p);
                        pos = free_cnt[p] - 1;
                        slot = pos < untouched[p] ? pos : stk[p][pos % StackDepth];
                        free_cnt[p] = pos;
                        move_list(p, k);
                        ga = (p * PageBytes + base_of(c) + slot * objsz(c)) & 18'h3ffff;
                    end
                end
            end else begin
                p = addr / PageBytes;
                off = addr % PageBytes;
                if (p >= NumPages || !owned[p]) st = StBadFree;
                else begin
                    c = cls_of[p];
                    if (off < base_of(c) || (off - base_of(c)) % objsz(c) != 0) begin
                        st = StBadFree;
                        c = 0;
                    end else if (free_cnt[p] >= slab_count(c)) st = StAllFree;
                    else begin
                        k = kind(p);
                        pos = free_cnt[p];
                        stk[p][pos % StackDepth] = (off - base_of(c)) / objsz(c);
                        if (pos < untouched[p]) untouched[p] = pos;
                        free_cnt[p] = pos + 1;
                        move_list(p, k);
                    end
                end
            end
            q_status.push_back(st[2:0]);
            q_addr.push_back(ga[AddrW-1:0]);
            q_cls.push_back(c[ClassW-1:0]);
        endfunction

        task check_result(logic [2:0] st, logic [AddrW-1:0] ga, logic [ClassW-1:0] c);
            if (q_status.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            if (st !== q_status[0])
                report_mismatch($sformatf("status %0d, wanted %0d", st, q_status[0]));
            if (ga !== q_addr[0])
                report_mismatch($sformatf("address %0h, wanted %0h", ga, q_addr[0]));
            if (c !== q_cls[0])
                report_mismatch($sformatf("class %0d, wanted %0d", c, q_cls[0]));
            void'(q_status.pop_front());
            void'(q_addr.pop_front());
            void'(q_cls.pop_front());
        endtask

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic              i_mode;
    logic [15:0]       i_request_size;
    logic [AddrW-1:0]  i_object_address;
    logic              empty;
    logic              pop;
    logic [2:0]        o_status;
    logic [AddrW-1:0]  o_granted_address;
    logic [ClassW-1:0] o_size_class;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [LimitW-1:0] i_cfg_page_limit;

    slab_size_class_allocator dut (.*);

    slab_scoreboard sb;
    int unsigned    cycle_count;
    bit             hold_off;
    bit             rx_stall_en;
    logic [AddrW-1:0] live_addrs [$];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: pop with random stalls, long hold when asked
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) pop <= 1'b0;
        else if (rx_stall_en) pop <= ($urandom_range(0, 9) > 2);
        else pop <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_status, o_granted_address, o_size_class);
            if (o_status == StOk && o_granted_address != 0 && $urandom_range(0, 1))
                live_addrs.push_back(o_granted_address);
        end
    end

    // push stays high into the next transaction when there is no gap
    task automatic send_request(bit is_free, int unsigned size, int unsigned addr);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        push <= 1'b1;
        i_mode <= is_free;
        i_request_size <= size[15:0];
        i_object_address <= addr[AddrW-1:0];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(is_free, size, addr);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int unsigned r, a;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            if ($urandom_range(0, 3) == 0) send_request(0, $urandom_range(0, 65535), 0);
            else send_request(0, $urandom_range(0, 1024) >> $urandom_range(0, 8), 0);
        end else if (r < 85 && live_addrs.size() > 0) begin
            a = $urandom_range(0, live_addrs.size() - 1);
            send_request(1, 0, live_addrs[a]);
            live_addrs.delete(a);
        end else if (r < 92) begin
            send_request(1, 0, $urandom_range(0, 262143));
        end else begin
            // 4-byte-aligned address on a random low page, maybe stale
            a = $urandom_range(0, 15) * PageBytes + PageBytes - 4 * $urandom_range(1, 64);
            send_request(1, $urandom, a);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.q_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(int unsigned v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_page_limit <= v[LimitW-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.limit = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned lims [4];
        sb = new();
        hold_off = 0;
        rx_stall_en = 1;
        push = 0;
        i_mode = 0;
        i_request_size = 0;
        i_object_address = 0;
        i_cfg_valid = 0;
        i_cfg_page_limit = 0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: classes 0, 1, 2, 4, 6 and 8, extremes, error cases
        write_limit(3);
        send_request(0, 0, 0);
        send_request(0, 4, 0);
        send_request(0, 5, 0);
        send_request(0, 1024, 0);
        send_request(0, 1025, 0);
        send_request(0, 65535, 0);
        send_request(0, 200, 0);
        send_request(0, 64, 0);
        send_request(1, 0, 262143);
        send_request(1, 0, 0);
        send_request(1, 0, 4096 + 3);
        drain();
        send_request(1, 16'hffff, sb.q_addr.size() == 0 ? 4096 - 4 : 0);
        send_request(1, 0, 4096 - 4);
        send_request(1, 0, 4096 - 4);
        send_request(1, 0, 4096 - 8);
        send_request(0, 16, 0);
        send_request(0, 0, 0);
        drain();

        // pressure: receiver holds off while sender keeps pushing
        hold_off = 1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                repeat (12) send_random();
                push <= 1'b0;
            end
        join
        drain();

        lims[0] = 64; lims[1] = 1; lims[2] = 127; lims[3] = 20;
        for (int ph = 0; ph < 4; ph++) begin
            write_limit(lims[ph]);
            rx_stall_en = (ph != 2);
            repeat (270) send_random();
            drain();
        end

        if (sb.errors == 0 && sb.q_status.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
